// ----- sv/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// Holds the opcode encoding and the command and status bundles that pass
// between the controller and the datapath. Depends on nothing.
package rau_pkg;

	// Opcode encoding of the input beat.
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;
	localparam logic [2:0] OP_RED = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;   // capture the accepted input beat
		logic mul0;      // first product
		logic mul1;      // second product
		logic mul2;      // product of the denominators
		logic form;      // form the exact numerator, denominator and order
		logic gcd_init;  // load operand magnitudes into the GCD unit
		logic gcd_step;  // one binary GCD step
		logic div_init;  // load the dividers with the final divisor
		logic div_step;  // one restoring division step on both lanes
		logic load_out;  // write the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_reduce;  // captured opcode is reduce
		logic trivial;    // reduce with a zero numerator or denominator
		logic gcd_done;   // GCD operands have met
		logic div_last;   // the divider is on its final step
		logic out_free;   // output register can take a new beat
	} status_t;

endpackage

// ----- sv/rau_ctrl.sv -----
// Controller state machine of the rational arithmetic unit.
// Sequences the product steps, the GCD loop and the divider of the datapath.
// Depends on rau_pkg for the command and status types.
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rau_pkg::status_t  st,
	output rau_pkg::cmd_t     cmd
);
	import rau_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_FORM = 3'd4;
	localparam logic [2:0] ST_GCD  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				if (st.is_reduce) begin
					if (st.trivial) begin
						state_d = ST_OUT;
					end else begin
						cmd.gcd_init = 1'b1;
						state_d      = ST_GCD;
					end
				end else begin
					cmd.mul0 = 1'b1;
					state_d  = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_FORM;
			end
			ST_FORM: begin
				cmd.form = 1'b1;
				state_d  = ST_OUT;
			end
			ST_GCD: begin
				if (st.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/rau_dp.sv -----
// Datapath of the rational arithmetic unit: operand registers, one shared
// signed multiplier, the binary GCD unit, two restoring divider lanes and
// the output register. Depends on rau_pkg.
module rau_dp #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::cmd_t       cmd,
	output rau_pkg::status_t    st,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  a_num,
	input  logic signed [31:0]  a_den,
	input  logic signed [31:0]  b_num,
	input  logic signed [31:0]  b_den,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  res_num,
	output logic signed [31:0]  res_den,
	output logic                is_less,
	output logic                is_greater,
	output logic                is_equal,
	output logic                zero_divisor,
	output logic                overflow
);
	import rau_pkg::*;

	localparam int W  = WORD_WIDTH;
	localparam int PW = 2 * WORD_WIDTH;
	localparam int KW = $clog2(WORD_WIDTH);

	// Captured operands, reduced to the word width.
	logic [2:0]          op_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= opcode;
			an_q <= a_num[W-1:0];
			ad_q <= a_den[W-1:0];
			bn_q <= b_num[W-1:0];
			bd_q <= b_den[W-1:0];
		end
	end

	// Shared multiplier; the operand pair follows the product step.
	logic signed [W-1:0]  mul_x, mul_y;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] p_q, q_q, d_q;

	always_comb begin
		mul_x = ad_q;
		mul_y = bd_q;
		if (cmd.mul0) begin
			mul_x = an_q;
			mul_y = (op_q == OP_MUL) ? bn_q : bd_q;
		end else if (cmd.mul1) begin
			mul_x = ad_q;
			mul_y = (op_q == OP_MUL) ? bd_q : bn_q;
		end
	end

	assign mul_p = PW'(mul_x) * PW'(mul_y);

	always_ff @(posedge clk) begin
		if (cmd.mul0) begin
			p_q <= mul_p;
		end
		if (cmd.mul1) begin
			q_q <= mul_p;
		end
		if (cmd.mul2) begin
			d_q <= mul_p;
		end
	end

	// Exact numerator and denominator, and the order of the cross products.
	logic signed [PW:0]   p_ext, q_ext;
	logic signed [PW:0]   rn_q;
	logic signed [PW-1:0] rd_q;
	logic                 lt_q, gt_q;

	assign p_ext = (PW+1)'(p_q);
	assign q_ext = (PW+1)'(q_q);

	always_ff @(posedge clk) begin
		if (cmd.form) begin
			case (op_q)
				OP_ADD:  rn_q <= p_ext + q_ext;
				OP_SUB:  rn_q <= p_ext - q_ext;
				default: rn_q <= p_ext;
			endcase
			rd_q <= (op_q inside {OP_ADD, OP_SUB}) ? d_q : q_q;
			lt_q <= (p_q < q_q);
			gt_q <= (p_q > q_q);
		end
	end

	// Binary GCD on the magnitudes of the first fraction.
	logic [W-1:0]  gx_q, gy_q;
	logic [KW-1:0] gk_q;
	logic [W-1:0]  an_mag, ad_mag;

	assign an_mag = an_q[W-1] ? W'(-an_q) : W'(an_q);
	assign ad_mag = ad_q[W-1] ? W'(-ad_q) : W'(ad_q);

	always_ff @(posedge clk) begin
		if (cmd.gcd_init) begin
			gx_q <= an_mag;
			gy_q <= ad_mag;
			gk_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				gk_q <= gk_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q > gy_q) begin
				gx_q <= (gx_q - gy_q) >> 1;
			end else begin
				gy_q <= (gy_q - gx_q) >> 1;
			end
		end
	end

	// Two restoring divider lanes sharing one divisor, one bit a cycle.
	logic [W-1:0]  dvs_q;
	logic [W-1:0]  rem_n_q, quo_n_q, rem_d_q, quo_d_q;
	logic [KW-1:0] div_cnt_q;
	logic [W:0]    sh_n, sh_d, dif_n, dif_d;

	assign sh_n  = {rem_n_q, quo_n_q[W-1]};
	assign sh_d  = {rem_d_q, quo_d_q[W-1]};
	assign dif_n = sh_n - {1'b0, dvs_q};
	assign dif_d = sh_d - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvs_q     <= gx_q << gk_q;
			rem_n_q   <= '0;
			rem_d_q   <= '0;
			quo_n_q   <= an_mag;
			quo_d_q   <= ad_mag;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			if (!dif_n[W]) begin
				rem_n_q <= dif_n[W-1:0];
				quo_n_q <= {quo_n_q[W-2:0], 1'b1};
			end else begin
				rem_n_q <= sh_n[W-1:0];
				quo_n_q <= {quo_n_q[W-2:0], 1'b0};
			end
			if (!dif_d[W]) begin
				rem_d_q <= dif_d[W-1:0];
				quo_d_q <= {quo_d_q[W-2:0], 1'b1};
			end else begin
				rem_d_q <= sh_d[W-1:0];
				quo_d_q <= {quo_d_q[W-2:0], 1'b0};
			end
		end
	end

	// Result selection for the output register.
	logic signed [W-1:0] red_n, red_d;
	logic signed [W-1:0] sel_n, sel_d;
	logic                sel_lt, sel_gt, sel_eq, sel_zd, sel_ov;
	logic                fit_n, fit_d;

	assign red_n = an_q[W-1] ? -$signed(quo_n_q) : $signed(quo_n_q);
	assign red_d = ad_q[W-1] ? -$signed(quo_d_q) : $signed(quo_d_q);
	assign fit_n = (rn_q[PW:W-1] == '0) || (rn_q[PW:W-1] == '1);
	assign fit_d = (rd_q[PW-1:W-1] == '0) || (rd_q[PW-1:W-1] == '1);

	always_comb begin
		sel_n  = '0;
		sel_d  = '0;
		sel_lt = 1'b0;
		sel_gt = 1'b0;
		sel_eq = 1'b0;
		sel_zd = 1'b0;
		sel_ov = 1'b0;
		case (op_q)
			OP_ADD, OP_SUB, OP_MUL: begin
				sel_n  = rn_q[W-1:0];
				sel_d  = rd_q[W-1:0];
				sel_ov = !(fit_n && fit_d);
			end
			OP_DIV: begin
				if (bn_q == '0) begin
					sel_zd = 1'b1;
				end else begin
					sel_n  = rn_q[W-1:0];
					sel_d  = rd_q[W-1:0];
					sel_ov = !(fit_n && fit_d);
				end
			end
			OP_CMP: begin
				sel_n  = rn_q[W-1:0];
				sel_d  = rd_q[W-1:0];
				sel_ov = !(fit_n && fit_d);
				sel_lt = lt_q;
				sel_gt = gt_q;
				sel_eq = (an_q == bn_q) && (ad_q == bd_q);
			end
			OP_RED: begin
				if (st.trivial) begin
					sel_n = an_q;
					sel_d = ad_q;
				end else begin
					sel_n = red_n;
					sel_d = red_d;
				end
			end
			default: begin
				sel_n = '0;
			end
		endcase
	end

	// Output register: holds a finished beat until it is taken.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_num      <= 32'(sel_n);
			res_den      <= 32'(sel_d);
			is_less      <= sel_lt;
			is_greater   <= sel_gt;
			is_equal     <= sel_eq;
			zero_divisor <= sel_zd;
			overflow     <= sel_ov;
		end
	end

	assign out_valid = out_valid_q;

	// Status back to the controller.
	assign st.is_reduce = (op_q == OP_RED);
	assign st.trivial   = (an_q == '0) || (ad_q == '0);
	assign st.gcd_done  = (gx_q == gy_q);
	assign st.div_last  = (div_cnt_q == KW'(W - 1));
	assign st.out_free  = !out_valid_q || out_ready;

endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
// Works on one beat at a time. Add, subtract, multiply, divide and compare
// pass through the product steps and the form step on their way to the
// output register; the single shared signed multiplier forms the three
// products one per cycle. Reduce with a zero part goes straight to the output
// register; otherwise the binary GCD loop runs until its operands meet, and
// the two restoring divider lanes then produce the quotients, one quotient
// bit a cycle. A finished result waits in the output register while the next
// input beat is accepted.
module rational_arithmetic_unit #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  a_num,
	input  logic signed [31:0]  a_den,
	input  logic signed [31:0]  b_num,
	input  logic signed [31:0]  b_den,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  res_num,
	output logic signed [31:0]  res_den,
	output logic                is_less,
	output logic                is_greater,
	output logic                is_equal,
	output logic                zero_divisor,
	output logic                overflow
);
	import rau_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequencer.
	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Arithmetic and output register.
	rau_dp #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.opcode       (opcode),
		.a_num        (a_num),
		.a_den        (a_den),
		.b_num        (b_num),
		.b_den        (b_den),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.res_num      (res_num),
		.res_den      (res_den),
		.is_less      (is_less),
		.is_greater   (is_greater),
		.is_equal     (is_equal),
		.zero_divisor (zero_divisor),
		.overflow     (overflow)
	);

endmodule
